// ===== rtl/trm_pkg.sv =====
`timescale 1ns / 1ps

package trm_pkg;

  // Default number of waiting elements.
  localparam int DEFAULT_DEPTH = 32;

  // Input command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Result kind codes.
  localparam logic [1:0] KIND_ELEM = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // Source of a result loaded into the output register.
  typedef enum logic [1:0] {
    SEL_HEAD = 2'd0,
    SEL_ITEM = 2'd1,
    SEL_DROP = 2'd2,
    SEL_DONE = 2'd3
  } trm_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     push;
    logic     pop;
    logic     set_owner;
    logic     set_ended;
    logic     clear;
    logic     emit;
    trm_sel_t emit_sel;
    logic     emit_last;
  } trm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       item_cmd;
    logic       item_run;
    logic [1:0] ended;
    logic       owner;
    logic       count_zero;
    logic       count_one;
    logic       count_full;
    logic       head_first;
    logic       slot_free;
  } trm_stat_t;

endpackage

// ===== rtl/two_run_merge_unit.sv =====
`timescale 1ns / 1ps
// Sequence: a request is taken in the idle state and decided in the evaluate state,
// where a push that only stores or emits one result completes. A push that overtakes
// the other run, or an end marker that flushes, then emits its results one at a time,
// with a final step once the buffer drains, each paced by the output register and the single buffer read port.
// Throughput: one request at a time; at most one result per cycle.
// Reset clears the controller, pointers, count, owner and ended flags, not the buffer.

module two_run_merge_unit import trm_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic               run,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [31:0] merged_value,
  output logic               last
);

  trm_cmd_t  cmd;
  trm_stat_t stat;

  // Sequencer.
  trm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Buffer, bookkeeping and output register.
  trm_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .command      (command),
    .run          (run),
    .value        (value),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .merged_value (merged_value),
    .last         (last)
  );

endmodule

// ===== rtl/trm_ctrl.sv =====
`timescale 1ns / 1ps

module trm_ctrl import trm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  trm_stat_t stat,
  output trm_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EVAL  = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_FLUSH = 4'b1000
  } trm_state_t;

  trm_state_t state, state_next;
  logic       done_pending, done_pending_next;
  logic       other_ended;

  assign in_ready    = (state == ST_IDLE);
  assign other_ended = stat.ended[~stat.item_run];

  // State and pending done marker.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done_pending <= 1'b0;
    end else begin
      state        <= state_next;
      done_pending <= done_pending_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next        = state;
    done_pending_next = done_pending;
    cmd               = '0;
    cmd.emit_sel      = SEL_HEAD;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.ended[stat.item_run]) begin
          // Requests to a run that has ended are ignored.
          state_next = ST_IDLE;
        end else if (stat.item_cmd == CMD_PUSH) begin
          if (stat.count_zero) begin
            if (other_ended) begin
              if (stat.slot_free) begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = SEL_ITEM;
                cmd.emit_last = 1'b1;
                state_next    = ST_IDLE;
              end
            end else begin
              cmd.push      = 1'b1;
              cmd.set_owner = 1'b1;
              state_next    = ST_IDLE;
            end
          end else if (stat.owner == stat.item_run) begin
            if (stat.count_full) begin
              if (stat.slot_free) begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = SEL_DROP;
                cmd.emit_last = 1'b1;
                state_next    = ST_IDLE;
              end
            end else begin
              cmd.push   = 1'b1;
              state_next = ST_IDLE;
            end
          end else begin
            state_next = ST_MERGE;
          end
        end else begin
          cmd.set_ended = 1'b1;
          if (other_ended) begin
            done_pending_next = 1'b1;
            state_next        = ST_FLUSH;
          end else if (!stat.count_zero && stat.owner != stat.item_run) begin
            done_pending_next = 1'b0;
            state_next        = ST_FLUSH;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_MERGE: begin
        if (!stat.count_zero && stat.head_first) begin
          // Waiting head goes out before the new element.
          if (stat.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = SEL_HEAD;
            cmd.emit_last = stat.count_one;
            cmd.pop       = 1'b1;
          end
        end else if (!stat.count_zero) begin
          if (stat.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = SEL_ITEM;
            cmd.emit_last = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          // The buffer drained, so the new element now waits.
          cmd.push      = 1'b1;
          cmd.set_owner = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!stat.count_zero) begin
          if (stat.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = SEL_HEAD;
            cmd.emit_last = stat.count_one && !done_pending;
            cmd.pop       = 1'b1;
          end
        end else if (done_pending) begin
          if (stat.slot_free) begin
            cmd.emit          = 1'b1;
            cmd.emit_sel      = SEL_DONE;
            cmd.emit_last     = 1'b1;
            cmd.clear         = 1'b1;
            done_pending_next = 1'b0;
            state_next        = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next        = ST_IDLE;
        done_pending_next = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/trm_datapath.sv =====
`timescale 1ns / 1ps

module trm_datapath import trm_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               command,
  input  logic               run,
  input  logic signed [31:0] value,
  input  trm_cmd_t           cmd,
  output trm_stat_t          stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [31:0] merged_value,
  output logic               last
);

  localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

  logic [31:0]      mem [BUFFER_DEPTH];
  logic [31:0]      head;
  logic             item_cmd;
  logic             item_run;
  logic [31:0]      item_value;
  logic [PTR_W-1:0] rd_ptr, wr_ptr, rd_ptr_inc, wr_ptr_inc, rd_addr;
  logic [CNT_W-1:0] count;
  logic             owner;
  logic [1:0]       ended;

  assign rd_ptr_inc = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;

  // The head register follows the pointer that will be current next cycle.
  always_comb begin
    if (cmd.clear) begin
      rd_addr = '0;
    end else if (cmd.pop) begin
      rd_addr = rd_ptr_inc;
    end else begin
      rd_addr = rd_ptr;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd   <= command;
      item_run   <= run;
      item_value <= value;
    end
  end

  // Waiting-element buffer with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr] <= item_value;
    end
    head <= mem[rd_addr];
  end

  // Buffer pointers, fill count and run bookkeeping.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
      owner  <= 1'b0;
      ended  <= 2'b00;
    end else begin
      if (cmd.pop) begin
        rd_ptr <= rd_ptr_inc;
      end
      if (cmd.push) begin
        wr_ptr <= wr_ptr_inc;
      end
      if (cmd.push && !cmd.pop) begin
        count <= count + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
        count <= count - 1'b1;
      end
      if (cmd.set_owner) begin
        owner <= item_run;
      end
      if (cmd.set_ended) begin
        ended[item_run] <= 1'b1;
      end
    end
  end

  // Output register; a new result is loaded only when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.emit_last;
      case (cmd.emit_sel)
        SEL_HEAD: begin
          kind         <= KIND_ELEM;
          merged_value <= head;
        end
        SEL_ITEM: begin
          kind         <= KIND_ELEM;
          merged_value <= item_value;
        end
        SEL_DROP: begin
          kind         <= KIND_DROP;
          merged_value <= '0;
        end
        default: begin
          kind         <= KIND_DONE;
          merged_value <= '0;
        end
      endcase
    end
  end

  // Status toward the controller. A waiting A element goes first only when
  // strictly smaller; a waiting B element also wins a tie.
  always_comb begin
    stat.item_cmd   = item_cmd;
    stat.item_run   = item_run;
    stat.ended      = ended;
    stat.owner      = owner;
    stat.count_zero = (count == '0);
    stat.count_one  = (count == CNT_W'(1));
    stat.count_full = (count >= CNT_FULL);
    stat.head_first = owner ? ($signed(head) <= $signed(item_value))
                            : ($signed(head) <  $signed(item_value));
    stat.slot_free  = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("fill count exceeds buffer depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("pop from empty buffer");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> count != CNT_FULL)
    else $error("push into full buffer");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> rd_ptr == wr_ptr)
    else $error("pointers disagree on empty buffer");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwrites one not yet taken");
`endif

endmodule

// ===== tb/sv/two_run_merge_unit_checker.sv =====
`timescale 1ns / 1ps

module two_run_merge_unit_checker import trm_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               command,
  input  logic               run,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         kind,
  input  logic signed [31:0] merged_value,
  input  logic               last,
  output int                 fail_count,
  output int                 pending_results,
  output int                 handled_reqs,
  output int                 results_seen,
  output int                 drops_seen,
  output int                 merges_done
);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] merged_value;
    logic               last;
  } merge_result_t;

  // Results still owed by the block, oldest first.
  merge_result_t expected_results[$];

  // Mirror of the block state: waiting elements, their run, and the ended runs.
  logic signed [31:0] waiting_elems[$];
  logic               owner_run;
  logic [1:0]         runs_ended;

  int err_cnt;
  int req_cnt;
  int res_cnt;
  int drop_cnt;
  int done_cnt;

  function automatic merge_result_t make_result(logic [1:0] k, logic signed [31:0] v);
    merge_result_t r;
    r.kind = k;
    r.merged_value = v;
    r.last = 1'b0;
    return r;
  endfunction

  // Work out the results of one accepted request and update the mirrored state.
  task automatic predict_merge(input logic cmd, input logic r, input logic signed [31:0] v);
    merge_result_t step_out[$];
    logic          head_first;
    logic          stop;
    begin
      // A request naming a run that has already ended is dropped silently.
      if (!runs_ended[r]) begin
        req_cnt++;
        if (cmd == CMD_PUSH) begin
          if (waiting_elems.size() == 0) begin
            if (runs_ended[!r]) begin
              step_out.insert(step_out.size(), make_result(KIND_ELEM, v));
            end else begin
              waiting_elems.insert(waiting_elems.size(), v);
              owner_run = r;
            end
          end else if (owner_run == r) begin
            if (waiting_elems.size() >= BUFFER_DEPTH) begin
              step_out.insert(step_out.size(), make_result(KIND_DROP, '0));
            end else begin
              waiting_elems.insert(waiting_elems.size(), v);
            end
          end else begin
            // Release waiting elements that sort ahead; ties favor run B.
            stop = 1'b0;
            while (waiting_elems.size() > 0 && !stop) begin
              head_first = (owner_run == 1'b0) ? (waiting_elems[0] < v)
                                               : (waiting_elems[0] <= v);
              if (head_first) begin
                step_out.insert(step_out.size(),
                                make_result(KIND_ELEM, waiting_elems.pop_front()));
              end else begin
                stop = 1'b1;
              end
            end
            if (waiting_elems.size() > 0) begin
              step_out.insert(step_out.size(), make_result(KIND_ELEM, v));
            end else begin
              waiting_elems.insert(waiting_elems.size(), v);
              owner_run = r;
            end
          end
        end else begin
          runs_ended[r] = 1'b1;
          if (runs_ended == 2'b11) begin
            while (waiting_elems.size() > 0) begin
              step_out.insert(step_out.size(),
                              make_result(KIND_ELEM, waiting_elems.pop_front()));
            end
            step_out.insert(step_out.size(), make_result(KIND_DONE, '0));
            owner_run = 1'b0;
            runs_ended = 2'b00;
          end else if (waiting_elems.size() > 0 && owner_run != r) begin
            while (waiting_elems.size() > 0) begin
              step_out.insert(step_out.size(),
                              make_result(KIND_ELEM, waiting_elems.pop_front()));
            end
          end
        end
      end
      if (step_out.size() > 0) begin
        step_out[step_out.size() - 1].last = 1'b1;
      end
      foreach (step_out[i]) begin
        expected_results.insert(expected_results.size(), step_out[i]);
      end
    end
  endtask

  // Compare each delivered result, then predict from the request taken at this edge.
  always @(posedge clk) begin
    merge_result_t exp_res;
    if (rst) begin
      expected_results.delete();
      waiting_elems.delete();
      owner_run = 1'b0;
      runs_ended = 2'b00;
      err_cnt = 0;
      req_cnt = 0;
      res_cnt = 0;
      drop_cnt = 0;
      done_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        res_cnt++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d, merged_value %0d, last %0b",
                 kind, merged_value, last);
          err_cnt++;
        end else begin
          exp_res = expected_results.pop_front();
          if (kind !== exp_res.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", exp_res.kind, kind);
            err_cnt++;
          end
          if (merged_value !== exp_res.merged_value) begin
            $error("merged_value mismatch: expected %0d, actual %0d",
                   exp_res.merged_value, merged_value);
            err_cnt++;
          end
          if (last !== exp_res.last) begin
            $error("last mismatch: expected %0b, actual %0b", exp_res.last, last);
            err_cnt++;
          end
          if (exp_res.kind == KIND_DROP) drop_cnt++;
          if (exp_res.kind == KIND_DONE) done_cnt++;
        end
      end
      if (in_valid && in_ready) begin
        predict_merge(command, run, value);
      end
    end
    fail_count      <= err_cnt;
    pending_results <= expected_results.size();
    handled_reqs    <= req_cnt;
    results_seen    <= res_cnt;
    drops_seen      <= drop_cnt;
    merges_done     <= done_cnt;
  end

endmodule

// ===== tb/sv/two_run_merge_unit_tb.sv =====
`timescale 1ns / 1ps

module two_run_merge_unit_tb;
  import trm_pkg::*;

  localparam int   DEPTH          = DEFAULT_DEPTH;
  localparam int   PHASE_REQS     = 85;
  localparam int   LONG_HOLD      = 300;
  localparam int   DRAIN_CYCLES   = 40;
  localparam int   WATCHDOG_LIMIT = 3000;
  localparam logic RUN_A          = 1'b0;
  localparam logic RUN_B          = 1'b1;
  localparam logic [31:0] MIN_VAL = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL = 32'h7FFF_FFFF;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               command;
  logic               run;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         kind;
  logic signed [31:0] merged_value;
  logic               last;

  int fail_count;
  int pending_results;
  int handled_reqs;
  int results_seen;
  int drops_seen;
  int merges_done;

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_requests;
  int holds_done;
  int idle_cycles;

  two_run_merge_unit #(.BUFFER_DEPTH(DEPTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .run          (run),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .merged_value (merged_value),
    .last         (last)
  );

  two_run_merge_unit_checker #(.BUFFER_DEPTH(DEPTH)) merge_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .run             (run),
    .value           (value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .merged_value    (merged_value),
    .last            (last),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .handled_reqs    (handled_reqs),
    .results_seen    (results_seen),
    .drops_seen      (drops_seen),
    .merges_done     (merges_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  initial begin
    out_ready <= 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_req(input logic cmd, input logic r, input logic [31:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    run      <= r;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results != 0);
  endtask

  // One pair of sorted runs, interleaved at random or led by a long burst on one run, or a burst of noise.
  task automatic merge_pair();
    int   a_vals[$];
    int   b_vals[$];
    int   len_a;
    int   len_b;
    int   mode;
    int   base;
    logic narrow;
    logic burst;
    logic burst_run;
    logic a_ended;
    logic b_ended;
    logic r;
    mode = $urandom_range(99);
    if (mode < 10) begin
      repeat ($urandom_range(1, 6)) begin
        send_req(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      end
    end else begin
      burst     = (mode < 25);
      burst_run = 1'($urandom_range(1));
      narrow    = 1'($urandom_range(1));
      base      = $urandom_range(20) - 10;
      len_a     = $urandom_range(10);
      len_b     = $urandom_range(10);
      if (burst) begin
        len_a = (burst_run == RUN_A) ? $urandom_range(30, 40) : $urandom_range(1, 4);
        len_b = (burst_run == RUN_B) ? $urandom_range(30, 40) : $urandom_range(1, 4);
      end
      repeat (len_a) a_vals.insert(a_vals.size(), narrow ? base + $urandom_range(12) : $urandom);
      repeat (len_b) b_vals.insert(b_vals.size(), narrow ? base + $urandom_range(12) : $urandom);
      a_vals.sort();
      b_vals.sort();
      a_ended = 1'b0;
      b_ended = 1'b0;
      while (a_vals.size() + b_vals.size() > 0) begin
        if (a_vals.size() == 0 || a_ended) r = RUN_B;
        else if (b_vals.size() == 0 || b_ended) r = RUN_A;
        else if (burst) r = burst_run;
        else r = 1'($urandom_range(1));
        send_req(CMD_PUSH, r, (r == RUN_B) ? b_vals.pop_front() : a_vals.pop_front());
        // A run that has run dry may end early; a stray push to it is ignored.
        if (!a_ended && a_vals.size() == 0 && $urandom_range(2) == 0) begin
          send_req(CMD_END, RUN_A, $urandom);
          a_ended = 1'b1;
          if ($urandom_range(9) == 0) send_req(CMD_PUSH, RUN_A, $urandom);
        end
        if (!b_ended && b_vals.size() == 0 && $urandom_range(2) == 0) begin
          send_req(CMD_END, RUN_B, $urandom);
          b_ended = 1'b1;
          if ($urandom_range(9) == 0) send_req(CMD_PUSH, RUN_B, $urandom);
        end
      end
      if ($urandom_range(1)) begin
        if (!a_ended) send_req(CMD_END, RUN_A, $urandom);
        if (!b_ended) send_req(CMD_END, RUN_B, $urandom);
      end else begin
        if (!b_ended) send_req(CMD_END, RUN_B, $urandom);
        if (!a_ended) send_req(CMD_END, RUN_A, $urandom);
      end
    end
  endtask

  initial begin
    int phase;
    int target;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    command  <= CMD_PUSH;
    run      <= RUN_A;
    value    <= '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_requests      = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: value extremes, ties both ways, early end, requests to ended runs.
    send_req(CMD_PUSH, RUN_A, MIN_VAL);
    send_req(CMD_PUSH, RUN_A, MAX_VAL);
    send_req(CMD_PUSH, RUN_B, MIN_VAL);
    send_req(CMD_PUSH, RUN_B, MAX_VAL);
    send_req(CMD_PUSH, RUN_B, 32'd5);
    send_req(CMD_END,  RUN_B, MAX_VAL);
    send_req(CMD_PUSH, RUN_B, 32'd7);
    send_req(CMD_END,  RUN_B, '0);
    send_req(CMD_PUSH, RUN_A, 32'hFFFF_FFFF);
    send_req(CMD_END,  RUN_A, MIN_VAL);
    send_req(CMD_PUSH, RUN_B, 32'd10);
    send_req(CMD_PUSH, RUN_B, 32'd20);
    send_req(CMD_PUSH, RUN_A, 32'd10);
    send_req(CMD_PUSH, RUN_A, 32'd30);
    send_req(CMD_END,  RUN_A, '0);
    send_req(CMD_PUSH, RUN_A, 32'd1);
    send_req(CMD_END,  RUN_B, 32'hFFFF_FFFF);
    send_req(CMD_PUSH, RUN_A, 32'h5555_5555);
    send_req(CMD_END,  RUN_A, 32'h5555_5555);
    send_req(CMD_PUSH, RUN_B, 32'hAAAA_AAAA);
    send_req(CMD_END,  RUN_B, 32'hAAAA_AAAA);
    wait_for_drain();

    // Random pairs of runs under four idling patterns.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          hold_requests++;
        end
        1: begin
          sender_idle_pct = 69;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 69;
        end
        default: begin
          sender_idle_pct = 18;
          receiver_stall_pct = 18;
        end
      endcase
      target = handled_reqs + PHASE_REQS;
      while (handled_reqs < target) merge_pair();
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests and %0d results, including %0d overflow drops.",
             handled_reqs, results_seen, drops_seen);
    $display("Completed %0d merges across four idling patterns and one long hold-off.",
             merges_done);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
